// ===== design/ttsp_pkg.sv =====
// ttsp_pkg: types and constants for the transposition table store/probe core.
// No dependencies.
package ttsp_pkg;

	localparam int TABLE_SLOTS = 65536;
	localparam int IDX_W       = $clog2(TABLE_SLOTS);
	localparam int CNT_W       = IDX_W + 1;
	localparam int CFG_W       = 17;
	localparam int KEY_W       = 64;
	localparam int MOVE_W      = 28;

	localparam logic [1:0] REQ_STORE = 2'd0;
	localparam logic [1:0] REQ_MOVE  = 2'd1;
	localparam logic [1:0] REQ_EVAL  = 2'd2;
	localparam logic [1:0] REQ_CLEAR = 2'd3;

	localparam logic [1:0] BOUND_ALPHA = 2'd1;
	localparam logic [1:0] BOUND_BETA  = 2'd2;
	localparam logic [1:0] BOUND_EXACT = 2'd3;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [KEY_W-1:0]  position_key;
		logic [MOVE_W-1:0] best_move;
		logic signed [15:0] eval_score;
		logic [5:0]        search_depth;
		logic [1:0]        bound_kind;
		logic signed [15:0] alpha_bound;
		logic signed [15:0] beta_bound;
	} req_t;

	typedef struct packed {
		logic [MOVE_W-1:0] returned_move;
		logic              entry_matched;
		logic [MOVE_W-1:0] entry_move;
		logic signed [15:0] result_score;
		logic              usable;
		logic [31:0]       new_write_count;
		logic [31:0]       over_write_count;
		logic [31:0]       hit_count;
		logic [31:0]       cut_count;
	} rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [MOVE_W-1:0] move;
		logic [15:0]       score;
		logic [5:0]        depth;
		logic [1:0]        bound;
	} entry_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		entry_t           wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} mem_ctl_t;

endpackage

// ===== design/transposition_table_store_probe_core.sv =====
// transposition_table_store_probe_core: top level, sequencer, counters and result word.
// Depends on ttsp_pkg, ttsp_mod_unit, ttsp_table.
//
//  channel   ports                   handshake
//  request   start, req, busy        taken when start && !busy
//  result    done, rsp               one-cycle strobe, no back-pressure
//  config    cfg_we, cfg_wdata       written when cfg_we
//
// Stores and probes first form the serial key remainder, then table read,
// evaluate and write. A clear zeroes the first n_eff slots, one slot a cycle.
// After reset busy stays high while every slot is zeroed. The result word appears
// the cycle after the sequencer finishes and stays until the next request overwrites it.
module transposition_table_store_probe_core import ttsp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  req_t             req,
	output logic             busy,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	output logic             done,
	output rsp_t             rsp
);

	localparam logic [2:0] ST_INIT = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_RD   = 3'd3;
	localparam logic [2:0] ST_EVAL = 3'd4;
	localparam logic [2:0] ST_CLR  = 3'd5;

	logic [2:0]       state_q;
	logic [CFG_W-1:0] cfg_q;
	req_t             req_q;
	logic [IDX_W-1:0] idx_q;
	logic [31:0]      nw_q, ow_q, hit_q, cut_q;
	logic             done_q;
	rsp_t             rsp_q;
	logic [CNT_W-1:0] n_eff;
	logic             div_go, div_done;
	logic [IDX_W-1:0] div_rem;
	mem_ctl_t         mctl;
	entry_t           rd;
	rsp_t             ev;
	rsp_t             clr_w;
	logic [31:0]      nw_d, ow_d, hit_d, cut_d;
	logic             kmatch;
	logic signed [15:0] s;

	always_comb begin
		if (cfg_q == '0) n_eff = CNT_W'(1);
		else if (32'(cfg_q) > TABLE_SLOTS) n_eff = CNT_W'(TABLE_SLOTS);
		else n_eff = CNT_W'(cfg_q);
	end

	assign div_go = (state_q == ST_IDLE) && start && (req.req_type != REQ_CLEAR);

	ttsp_mod_unit u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (div_go),
		.dividend(req.position_key),
		.divisor (n_eff),
		.done    (div_done),
		.rem     (div_rem)
	);

	ttsp_table u_tab (
		.clk  (clk),
		.ctl  (mctl),
		.rdata(rd)
	);

	assign kmatch = rd.key == req_q.position_key;
	assign s      = rd.score;

	always_comb begin
		ev    = '0;
		nw_d  = nw_q;
		ow_d  = ow_q;
		hit_d = hit_q;
		cut_d = cut_q;
		unique case (req_q.req_type)
			REQ_STORE: begin
				if (rd.key == '0) nw_d = nw_q + 32'd1;
				else              ow_d = ow_q + 32'd1;
			end
			REQ_MOVE: begin
				if (kmatch) begin
					ev.entry_matched = 1'b1;
					ev.entry_move    = rd.move;
					ev.returned_move = rd.move;
				end
			end
			REQ_EVAL: begin
				if (kmatch && rd.depth >= req_q.search_depth) begin
					ev.entry_matched = 1'b1;
					ev.entry_move    = rd.move;
					ev.result_score  = s;
					hit_d = hit_q + 32'd1;
					if (rd.bound == BOUND_EXACT) begin
						ev.usable = 1'b1;
					end else if (rd.bound == BOUND_ALPHA && s <= req_q.alpha_bound) begin
						ev.usable       = 1'b1;
						ev.result_score = req_q.alpha_bound;
					end else if (rd.bound == BOUND_BETA && s >= req_q.beta_bound) begin
						ev.usable       = 1'b1;
						ev.result_score = req_q.beta_bound;
						cut_d = cut_q + 32'd1;
					end
					if (ev.usable) ev.returned_move = rd.move;
				end
			end
			default: begin
			end
		endcase
		ev.new_write_count  = nw_d;
		ev.over_write_count = ow_d;
		ev.hit_count        = hit_d;
		ev.cut_count        = cut_d;
	end

	always_comb begin
		clr_w                  = '0;
		clr_w.over_write_count = ow_q;
		clr_w.hit_count        = hit_q;
		clr_w.cut_count        = cut_q;
	end

	always_comb begin
		mctl       = '0;
		mctl.raddr = idx_q;
		mctl.re    = (state_q == ST_RD);
		mctl.waddr = idx_q;
		if (state_q == ST_INIT || state_q == ST_CLR) begin
			mctl.we = 1'b1;
		end else if (state_q == ST_EVAL && req_q.req_type == REQ_STORE) begin
			mctl.we          = 1'b1;
			mctl.wdata.key   = req_q.position_key;
			mctl.wdata.move  = req_q.best_move;
			mctl.wdata.score = req_q.eval_score;
			mctl.wdata.depth = req_q.search_depth;
			mctl.wdata.bound = req_q.bound_kind;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			cfg_q   <= CFG_W'(TABLE_SLOTS);
			idx_q   <= '0;
			nw_q    <= '0;
			ow_q    <= '0;
			hit_q   <= '0;
			cut_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) cfg_q <= cfg_wdata;
			unique case (state_q)
				ST_INIT: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == IDX_W'(TABLE_SLOTS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (start) begin
						idx_q <= '0;
						if (req.req_type == REQ_CLEAR) state_q <= ST_CLR;
						else                           state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						idx_q   <= div_rem;
						state_q <= ST_RD;
					end
				end
				ST_RD: state_q <= ST_EVAL;
				ST_EVAL: begin
					nw_q    <= nw_d;
					ow_q    <= ow_d;
					hit_q   <= hit_d;
					cut_q   <= cut_d;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_CLR: begin
					idx_q <= idx_q + 1'b1;
					if ({1'b0, idx_q} == n_eff - 1'b1) begin
						nw_q    <= '0;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) req_q <= req;
		if (state_q == ST_EVAL) begin
			rsp_q <= ev;
		end else if (state_q == ST_CLR) begin
			rsp_q <= clr_w;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ===== design/ttsp_mod_unit.sv =====
// ttsp_mod_unit: bit-serial restoring remainder of a 64-bit key by the slot count.
// Depends on ttsp_pkg.
module ttsp_mod_unit import ttsp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [KEY_W-1:0] dividend,
	input  logic [CNT_W-1:0] divisor,
	output logic             done,
	output logic [IDX_W-1:0] rem
);

	localparam int STEP_W = $clog2(KEY_W);

	logic             run_q;
	logic [STEP_W-1:0] step_q;
	logic [KEY_W-1:0] num_q;
	logic [CNT_W-1:0] div_q;
	logic [CNT_W-1:0] rem_q;
	logic             done_q;
	logic [CNT_W:0]   trial;
	logic [CNT_W:0]   diff;

	assign trial = {rem_q, num_q[KEY_W-1]};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(KEY_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			num_q <= {num_q[KEY_W-2:0], 1'b0};
			if (!diff[CNT_W]) rem_q <= diff[CNT_W-1:0];
			else              rem_q <= trial[CNT_W-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q[IDX_W-1:0];

endmodule

// ===== design/ttsp_table.sv =====
// ttsp_table: slot store, one write and one registered read port.
// Depends on ttsp_pkg.
module ttsp_table import ttsp_pkg::*; (
	input  logic     clk,
	input  mem_ctl_t ctl,
	output entry_t   rdata
);

	entry_t mem [TABLE_SLOTS];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (ctl.we) mem[ctl.waddr] <= ctl.wdata;
		if (ctl.re) rdata_q <= mem[ctl.raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== dv/ttsp_checker.sv =====
// ttsp_checker: predicts and checks every result word of the transposition table core.
// Depends on ttsp_pkg; watches the request, result and config channels of the block.
`timescale 1ns / 1ps
module ttsp_checker import ttsp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  req_t             req,
	input  logic             done,
	input  rsp_t             rsp,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	output int               fails,
	output int               pending
);

	bit [KEY_W-1:0]  tbl_key   [TABLE_SLOTS];
	bit [MOVE_W-1:0] tbl_move  [TABLE_SLOTS];
	bit [15:0]       tbl_score [TABLE_SLOTS];
	bit [5:0]        tbl_depth [TABLE_SLOTS];
	bit [1:0]        tbl_bound [TABLE_SLOTS];
	bit [31:0]       n_new, n_over, n_hit, n_cut;
	bit [CFG_W-1:0]  slots_cfg = CFG_W'(TABLE_SLOTS);
	rsp_t            expected_words [$];

	initial fails = 0;
	assign pending = expected_words.size();

	function automatic rsp_t lookup_update(req_t r);
		rsp_t o;
		int unsigned n;
		int unsigned idx;
		logic signed [15:0] s;
		logic match;
		o = '0;
		n = slots_cfg;
		if (n < 1) n = 1;
		if (n > TABLE_SLOTS) n = TABLE_SLOTS;
		idx = int'(r.position_key % n);
		match = (tbl_key[idx] == r.position_key);
		case (r.req_type)
			REQ_STORE: begin
				if (tbl_key[idx] == '0) n_new++;
				else n_over++;
				tbl_key[idx]   = r.position_key;
				tbl_move[idx]  = r.best_move;
				tbl_score[idx] = r.eval_score;
				tbl_depth[idx] = r.search_depth;
				tbl_bound[idx] = r.bound_kind;
			end
			REQ_MOVE: begin
				if (match) begin
					o.entry_matched = 1'b1;
					o.entry_move    = tbl_move[idx];
					o.returned_move = tbl_move[idx];
				end
			end
			REQ_EVAL: begin
				if (match && tbl_depth[idx] >= r.search_depth) begin
					s = tbl_score[idx];
					o.entry_matched = 1'b1;
					o.entry_move    = tbl_move[idx];
					o.result_score  = s;
					n_hit++;
					if (tbl_bound[idx] == BOUND_EXACT) begin
						o.usable = 1'b1;
					end else if (tbl_bound[idx] == BOUND_ALPHA && s <= r.alpha_bound) begin
						o.result_score = r.alpha_bound;
						o.usable = 1'b1;
					end else if (tbl_bound[idx] == BOUND_BETA && s >= r.beta_bound) begin
						o.result_score = r.beta_bound;
						n_cut++;
						o.usable = 1'b1;
					end
					if (o.usable) o.returned_move = tbl_move[idx];
				end
			end
			default: begin
				for (int unsigned i = 0; i < n; i++) begin
					tbl_key[i]   = '0;
					tbl_move[i]  = '0;
					tbl_score[i] = '0;
					tbl_depth[i] = '0;
					tbl_bound[i] = '0;
				end
				n_new = '0;
			end
		endcase
		o.new_write_count  = n_new;
		o.over_write_count = n_over;
		o.hit_count        = n_hit;
		o.cut_count        = n_cut;
		return o;
	endfunction

	function automatic void cmp_field(string name, logic [63:0] e, logic [63:0] a);
		if (e !== a) begin
			fails++;
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, e, a);
		end
	endfunction

	always @(posedge clk) begin
		rsp_t e;
		if (arst_n) begin
			if (cfg_we) slots_cfg <= cfg_wdata;
			if (start && !busy) expected_words.push_back(lookup_update(req));
			if (done) begin
				if (expected_words.size() == 0) begin
					fails++;
					$display("%0t: unexpected result word: expected none, actual %0h", $time, rsp);
				end else begin
					e = expected_words.pop_front();
					cmp_field("returned_move", e.returned_move, rsp.returned_move);
					cmp_field("entry_matched", e.entry_matched, rsp.entry_matched);
					cmp_field("entry_move", e.entry_move, rsp.entry_move);
					cmp_field("result_score", e.result_score, rsp.result_score);
					cmp_field("usable", e.usable, rsp.usable);
					cmp_field("new_write_count", e.new_write_count, rsp.new_write_count);
					cmp_field("over_write_count", e.over_write_count, rsp.over_write_count);
					cmp_field("hit_count", e.hit_count, rsp.hit_count);
					cmp_field("cut_count", e.cut_count, rsp.cut_count);
				end
			end
		end
	end

endmodule

// ===== dv/tb.sv =====
// tb: stimulus and verdict for transposition_table_store_probe_core.
// Depends on ttsp_pkg, the core and ttsp_checker, which does all prediction and checking.
`timescale 1ns / 1ps
module tb;
	import ttsp_pkg::*;

	localparam int STALL_LIMIT = 200000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	req_t             req = '0;
	logic             busy;
	logic             cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic             done;
	rsp_t             rsp;
	int               fails;
	int               pending;
	int               stall_cycles = 0;
	bit               gaps_on = 1'b1;
	logic [KEY_W-1:0] key_pool [$];

	transposition_table_store_probe_core uut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req), .busy(busy),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .rsp(rsp)
	);

	ttsp_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.fails(fails), .pending(pending)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send_word(req_t r);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (r.req_type == REQ_STORE) begin
			key_pool.push_back(r.position_key);
			if (key_pool.size() > 24) void'(key_pool.pop_front());
		end
	endtask

	task automatic drain_and_config(logic [CFG_W-1:0] v);
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic req_t mk(logic [1:0] t, logic [63:0] k, logic [27:0] m,
			logic [15:0] s, logic [5:0] d, logic [1:0] b, logic [15:0] a, logic [15:0] be);
		req_t r;
		r.req_type = t; r.position_key = k; r.best_move = m; r.eval_score = s;
		r.search_depth = d; r.bound_kind = b; r.alpha_bound = a; r.beta_bound = be;
		return r;
	endfunction

	function automatic logic [63:0] pick_key(int fresh_pct);
		int p;
		p = $urandom_range(0, 99);
		if (p < fresh_pct || key_pool.size() == 0) begin
			case ($urandom_range(0, 3))
				0: return 64'($urandom_range(0, 300));
				1: return 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 3);
				default: return {$urandom, $urandom};
			endcase
		end
		if (p > 92) return '0;
		return key_pool[$urandom_range(0, key_pool.size() - 1)];
	endfunction

	function automatic req_t random_word(bit clears);
		req_t r;
		int p;
		r = mk(REQ_STORE, '0, 28'($urandom), 16'($urandom), 6'($urandom),
			2'($urandom), 16'($urandom), 16'($urandom));
		if ($urandom_range(0, 1)) r.search_depth = 6'($urandom_range(0, 8));
		p = $urandom_range(0, 99);
		if (p < 35) begin
			r.position_key = pick_key(60);
		end else if (p < 55) begin
			r.req_type = REQ_MOVE;
			r.position_key = pick_key(15);
		end else if (p < 97 || !clears) begin
			r.req_type = REQ_EVAL;
			r.position_key = pick_key(15);
		end else begin
			r.req_type = REQ_CLEAR;
			r.position_key = pick_key(50);
		end
		return r;
	endfunction

	initial begin
		logic [CFG_W-1:0] cfg_vals [7];
		int               cfg_items [7];
		bit               cfg_clear [7];
		cfg_vals  = '{17'd0, 17'd1, 17'd7, 17'h1FFFF, 17'd33, 17'd65535, 17'd250};
		cfg_items = '{100, 80, 150, 80, 150, 60, 230};
		cfg_clear = '{1, 1, 1, 0, 1, 0, 1};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);

		// directed: full table size after reset
		send_word(mk(REQ_EVAL, '0, '0, '0, '0, '0, '0, '0));
		send_word(mk(REQ_MOVE, '0, '0, '0, '0, '0, '0, '0));
		send_word(mk(REQ_STORE, 64'h1_0000, 28'hFFF_FFFF, 16'h7FFF, 6'd63, BOUND_EXACT, '0, '0));
		send_word(mk(REQ_STORE, '1, 28'd1, 16'h8000, 6'd0, BOUND_ALPHA, '0, '0));
		send_word(mk(REQ_STORE, 64'd5, 28'h123_4567, 16'd100, 6'd20, BOUND_BETA, '0, '0));
		send_word(mk(REQ_STORE, 64'd9, 28'hABC, 16'd7, 6'd30, 2'd0, '0, '0));
		send_word(mk(REQ_STORE, 64'h2_0005, 28'h55, -16'sd50, 6'd10, BOUND_ALPHA, '0, '0));
		send_word(mk(REQ_MOVE, 64'h1_0000, '0, '0, '0, '0, '0, '0));
		send_word(mk(REQ_MOVE, 64'd0, '0, '0, '0, '0, '0, '0));
		send_word(mk(REQ_EVAL, 64'h1_0000, '0, '0, 6'd63, '0, 16'h8000, 16'h7FFF));
		send_word(mk(REQ_EVAL, '1, '0, '0, 6'd0, '0, 16'h8000, '0));
		send_word(mk(REQ_EVAL, '1, '0, '0, 6'd0, '0, 16'h7FFF, '0));
		send_word(mk(REQ_EVAL, 64'd5, '0, '0, 6'd20, '0, '0, 16'd100));
		send_word(mk(REQ_EVAL, 64'd5, '0, '0, 6'd20, '0, '0, 16'd101));
		send_word(mk(REQ_EVAL, 64'd5, '0, '0, 6'd21, '0, '0, 16'h8000));
		send_word(mk(REQ_EVAL, 64'd9, '0, '0, 6'd1, '0, 16'h7FFF, 16'h8000));
		send_word(mk(REQ_EVAL, 64'h2_0005, '0, '0, 6'd10, '0, -16'sd50, '0));
		send_word(mk(REQ_EVAL, 64'h2_0005, '0, '0, 6'd10, '0, -16'sd51, '0));
		send_word(mk(REQ_STORE, 64'd5, 28'd3, 16'd1, 6'd1, BOUND_EXACT, '0, '0));
		send_word(mk(REQ_CLEAR, '0, '0, '0, '0, '0, '0, '0));
		send_word(mk(REQ_MOVE, 64'h1_0000, '0, '0, '0, '0, '0, '0));
		send_word(mk(REQ_STORE, 64'd5, 28'd3, 16'd1, 6'd1, BOUND_EXACT, '0, '0));

		for (int ph = 0; ph < 7; ph++) begin
			drain_and_config(cfg_vals[ph]);
			key_pool.delete();
			for (int i = 0; i < cfg_items[ph]; i++) begin
				gaps_on = (ph < 6) && ($urandom_range(0, 9) != 0 || i % 40 < 20);
				send_word(random_word(cfg_clear[ph]));
			end
		end

		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fails == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
